// File: hdl/pvo_pkg.sv
// ----------------------------------------------------------------------------
// pvo_pkg
// Shared widths, command and status types and helpers for the polygon
// vertex offset unit.
// ----------------------------------------------------------------------------
package pvo_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W   = 24;              // signed q16.8 coordinate
    localparam int DIFF_W    = COORD_W + 1;     // edge component
    localparam int OFF_W     = 16;              // unsigned q8.8 offset
    localparam int OFF_SHIFT = 6;               // offset * 64
    localparam int NRM_W     = 19;              // normal component
    localparam int MOP_W     = 25;              // multiplier operand
    localparam int PROD_W    = 2 * MOP_W;
    localparam int ACC_W     = 72;
    localparam int LEN2_W    = 50;
    localparam int LEN_SHIFT = 12;
    localparam int RAD_W     = LEN2_W + LEN_SHIFT;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int DVD_W     = 70;              // divider dividend / quotient
    localparam int DVS_W     = 51;              // divider divisor / remainder
    localparam int DEN_W     = 51;
    localparam int NUM_W     = 46;
    localparam int NL_W      = 23;              // low slice of num per product
    localparam int QC_W      = 41;              // capped quotient magnitude
    localparam int Q_W       = QC_W + 1;
    localparam int SUM_W     = 43;

    localparam int SQRT_ITERS = ROOT_W;
    localparam int DIV_ITERS  = DVD_W;

    localparam logic [OFF_W-1:0] OFF_RESET = 16'd3840;
    localparam logic [QC_W-1:0]  Q_CAP     = {1'b1, {(QC_W-1){1'b0}}};

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DX2_DX2,
        MUL_DY2_DY2,
        MUL_DY2_OFF,
        MUL_DX2_OFF,
        MUL_DY1_DX2,
        MUL_DX1_DY2,
        MUL_DNX_DY2,
        MUL_DNY_DX2,
        MUL_DX1_NH,
        MUL_DX1_NL,
        MUL_DY1_NH,
        MUL_DY1_NL
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SHADD
    } acc_op_t;

    typedef enum logic [1:0] {
        DIV_NX,
        DIV_NY,
        DIV_QX,
        DIV_QY
    } div_dest_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              ld_a;
        logic              ld_b;
        logic              mk_edge;
        mul_sel_t          mul_sel;
        acc_op_t           acc_op;
        logic              sqrt_start;
        logic              div_start;
        div_dest_t         div_dest;
        logic              ld_den;
        logic              ld_num;
        logic              zero_n2;
        logic              clr_q;
        logic              advance;
        logic              emit;
        logic              emit_last;
        logic              emit_degen;
    } pvo_cmd_t;

    typedef struct packed {
        logic acc_zero;
        logic den_zero;
        logic ok1;
        logic ok2;
        logic sqrt_done;
        logic div_done;
        logic out_free;
    } pvo_stat_t;

    localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'(2 ** (COORD_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(2 ** (COORD_W - 1));

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > COORD_MAX)
        begin
            r = COORD_MAX[COORD_W-1:0];
        end
        else if (v < COORD_MIN)
        begin
            r = COORD_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/pvo_sqrt.sv
// ----------------------------------------------------------------------------
// pvo_sqrt
// Integer square root, restoring, one result bit per cycle.
// ----------------------------------------------------------------------------
module pvo_sqrt
    import pvo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0]        x_reg, x_next;
    logic [RAD_W-1:0]        res_reg, res_next;
    logic [RAD_W-1:0]        bit_reg, bit_next;
    logic [$clog2(SQRT_ITERS)-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [RAD_W:0]          trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            res_next  = '0;
            bit_next  = RAD_W'(1) << (RAD_W - 2);
            cnt_next  = $bits(cnt_reg)'(SQRT_ITERS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, x_reg} >= trial)
            begin
                x_next   = x_reg - trial[RAD_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

// File: hdl/pvo_div.sv
// ----------------------------------------------------------------------------
// pvo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvo_div
    import pvo_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [$clog2(DIV_ITERS)-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rs;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rs   = {rem_reg, quo_reg[DVD_W-1]};
    assign ge   = rs >= {1'b0, dvs_reg};
    assign diff = rs - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = $bits(cnt_reg)'(DIV_ITERS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : rs[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/pvo_datapath.sv
// ----------------------------------------------------------------------------
// pvo_datapath
// Vertex store, shared multiply-accumulate, square root and divider, edge and
// normal registers, and the result register.
// ----------------------------------------------------------------------------
module pvo_datapath
    import pvo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pvo_cmd_t             cmd,
    output pvo_stat_t            stat,
    input  logic [2*COORD_W-1:0] s_tdata,
    input  logic                 cfg_valid,
    input  logic [OFF_W-1:0]     cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*COORD_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    logic [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_y [MAX_VERTICES];
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg;

    logic [OFF_W-1:0] off_reg;

    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [DIFF_W-1:0]  dx1_reg, dy1_reg, dx2_reg, dy2_reg;
    logic signed [NRM_W-1:0]   n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic                      ok1_reg, ok2_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DEN_W-1:0]   den_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [Q_W-1:0]     qx_reg, qy_reg;
    div_dest_t                 dest_reg;
    logic                      neg_reg;

    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_degen_reg, out_last_reg;
    logic               out_valid_reg;

    // multiplier operands
    logic signed [NRM_W:0]        dnx, dny;
    logic signed [NUM_W-NL_W-1:0] num_hi;
    logic signed [MOP_W-1:0]      num_lo;
    logic signed [MOP_W-1:0]      off_op;
    logic signed [MOP_W-1:0]      op_a, op_b;
    logic signed [PROD_W-1:0]     prod;

    logic [ACC_W-1:0] acc_mag;
    logic [DEN_W-1:0] den_mag;

    logic              sqrt_done;
    logic [ROOT_W-1:0] root;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic              div_done;
    logic [DVD_W-1:0]  quo;
    logic [DVS_W-1:0]  rem;

    logic signed [NRM_W-1:0] qn_pos;
    logic                    rnd;
    logic [DVD_W:0]          qr;
    logic [QC_W-1:0]         qc;
    logic signed [Q_W-1:0]   qs;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    assign dnx    = {n1x_reg[NRM_W-1], n1x_reg} - {n2x_reg[NRM_W-1], n2x_reg};
    assign dny    = {n2y_reg[NRM_W-1], n2y_reg} - {n1y_reg[NRM_W-1], n1y_reg};
    assign num_hi = num_reg[NUM_W-1:NL_W];
    assign num_lo = {{(MOP_W-NL_W){1'b0}}, num_reg[NL_W-1:0]};
    assign off_op = {{(MOP_W-OFF_W-OFF_SHIFT){1'b0}}, off_reg, {OFF_SHIFT{1'b0}}};

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            MUL_DX2_DX2: begin op_a = dx2_reg;          op_b = dx2_reg;          end
            MUL_DY2_DY2: begin op_a = dy2_reg;          op_b = dy2_reg;          end
            MUL_DY2_OFF: begin op_a = dy2_reg;          op_b = off_op;           end
            MUL_DX2_OFF: begin op_a = dx2_reg;          op_b = off_op;           end
            MUL_DY1_DX2: begin op_a = dy1_reg;          op_b = dx2_reg;          end
            MUL_DX1_DY2: begin op_a = dx1_reg;          op_b = dy2_reg;          end
            MUL_DNX_DY2: begin op_a = MOP_W'(dnx);      op_b = dy2_reg;          end
            MUL_DNY_DX2: begin op_a = MOP_W'(dny);      op_b = dx2_reg;          end
            MUL_DX1_NH:  begin op_a = dx1_reg;          op_b = MOP_W'(num_hi);   end
            MUL_DX1_NL:  begin op_a = dx1_reg;          op_b = num_lo;           end
            MUL_DY1_NH:  begin op_a = dy1_reg;          op_b = MOP_W'(num_hi);   end
            MUL_DY1_NL:  begin op_a = dy1_reg;          op_b = num_lo;           end
            default:     begin op_a = '0;               op_b = '0;               end
        endcase
    end

    assign prod = op_a * op_b;

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD:  acc_next = ACC_W'(prod);
            ACC_ADD:   acc_next = acc_reg + ACC_W'(prod);
            ACC_SUB:   acc_next = acc_reg - ACC_W'(prod);
            ACC_SHADD: acc_next = (acc_reg <<< NL_W) + ACC_W'(prod);
            default:   acc_next = acc_reg;
        endcase
    end

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign den_mag = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : den_reg;

    // divider operands: rounded edge normal or intersection quotient
    always_comb
    begin
        if (cmd.div_dest == DIV_NX || cmd.div_dest == DIV_NY)
        begin
            dvd = acc_mag[DVD_W-1:0] + DVD_W'(root >> 1);
            dvs = DVS_W'(root);
        end
        else
        begin
            dvd = acc_mag[DVD_W-1:0];
            dvs = den_mag[DVS_W-1:0];
        end
    end

    pvo_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand ({acc_reg[LEN2_W-1:0], {LEN_SHIFT{1'b0}}}),
        .done     (sqrt_done),
        .root     (root)
    );

    pvo_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    // quotient post-processing: normal sign, intersection rounding and cap
    assign qn_pos = signed'(quo[NRM_W-1:0]);
    assign rnd    = {rem, 1'b0} >= {1'b0, den_mag[DVS_W-1:0]};
    assign qr     = {1'b0, quo} + (DVD_W+1)'(rnd);
    assign qc     = (qr > (DVD_W+1)'(Q_CAP)) ? Q_CAP : qr[QC_W-1:0];
    assign qs     = neg_reg ? -signed'({1'b0, qc}) : signed'({1'b0, qc});

    assign sum_x = SUM_W'(xa_reg) + SUM_W'(n1x_reg) + SUM_W'(qx_reg);
    assign sum_y = SUM_W'(ya_reg) + SUM_W'(n1y_reg) + SUM_W'(qy_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_x[cmd.wr_addr] <= s_tdata[COORD_W-1:0];
            mem_y[cmd.wr_addr] <= s_tdata[2*COORD_W-1:COORD_W];
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[cmd.rd_addr];
            rd_y_reg <= mem_y[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg       <= OFF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                off_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.ld_a)
        begin
            xa_reg <= signed'(rd_x_reg);
            ya_reg <= signed'(rd_y_reg);
        end
        if (cmd.ld_b)
        begin
            xb_reg <= signed'(rd_x_reg);
            yb_reg <= signed'(rd_y_reg);
        end
        if (cmd.mk_edge)
        begin
            dx2_reg <= DIFF_W'(xb_reg) - DIFF_W'(xa_reg);
            dy2_reg <= DIFF_W'(yb_reg) - DIFF_W'(ya_reg);
        end
        if (cmd.ld_den)
        begin
            den_reg <= acc_reg[DEN_W-1:0];
        end
        if (cmd.ld_num)
        begin
            num_reg <= acc_reg[NUM_W-1:0];
        end
        if (cmd.div_start)
        begin
            dest_reg <= cmd.div_dest;
            if (cmd.div_dest == DIV_NX || cmd.div_dest == DIV_NY)
            begin
                neg_reg <= acc_reg[ACC_W-1];
            end
            else
            begin
                neg_reg <= acc_reg[ACC_W-1] ^ den_reg[DEN_W-1];
            end
        end
        if (cmd.zero_n2)
        begin
            n2x_reg <= '0;
            n2y_reg <= '0;
            ok2_reg <= 1'b0;
        end
        if (cmd.clr_q)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
        end
        if (div_done)
        begin
            case (dest_reg)
                DIV_NX: n2x_reg <= neg_reg ? qn_pos : -qn_pos;
                DIV_NY:
                begin
                    n2y_reg <= neg_reg ? -qn_pos : qn_pos;
                    ok2_reg <= 1'b1;
                end
                DIV_QX: qx_reg <= qs;
                DIV_QY: qy_reg <= qs;
                default: ;
            endcase
        end
        if (cmd.advance)
        begin
            n1x_reg <= n2x_reg;
            n1y_reg <= n2y_reg;
            ok1_reg <= ok2_reg;
            dx1_reg <= dx2_reg;
            dy1_reg <= dy2_reg;
            xa_reg  <= xb_reg;
            ya_reg  <= yb_reg;
        end
        if (cmd.emit)
        begin
            out_x_reg     <= sat_coord(sum_x);
            out_y_reg     <= sat_coord(sum_y);
            out_degen_reg <= cmd.emit_degen;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign stat.acc_zero  = (acc_reg == '0);
    assign stat.den_zero  = (den_reg == '0);
    assign stat.ok1       = ok1_reg;
    assign stat.ok2       = ok2_reg;
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_degen_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/pvo_ctrl.sv
// ----------------------------------------------------------------------------
// pvo_ctrl
// Sequencer: vertex loading, then per vertex the edge normal, the
// intersection terms and the result hand-off.
// ----------------------------------------------------------------------------
module pvo_ctrl
    import pvo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  pvo_stat_t stat,
    output pvo_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_INIT_A,
        ST_INIT_B,
        ST_INIT_C,
        ST_VRD,
        ST_VCAP,
        ST_EDGE,
        ST_SQ1,
        ST_SQ2,
        ST_LENCHK,
        ST_SQRT_WAIT,
        ST_PX,
        ST_DX_GO,
        ST_DX_WAIT,
        ST_PY,
        ST_DY_GO,
        ST_DY_WAIT,
        ST_NORM_DONE,
        ST_DEN1,
        ST_DEN2,
        ST_DEN3,
        ST_CHK,
        ST_NUM1,
        ST_NUM2,
        ST_NUM3,
        ST_MX1,
        ST_MX2,
        ST_MX_GO,
        ST_MX_WAIT,
        ST_MY1,
        ST_MY2,
        ST_MY_GO,
        ST_MY_WAIT,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic              init_reg, init_next;
    logic              degen_reg, degen_next;

    logic              accept;
    logic              room;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  n_m1;
    logic              j_last;
    logic [ADDR_W-1:0] k_addr;
    logic              degen_now;

    assign s_tready  = (state_reg == ST_LOAD);
    assign accept    = s_tvalid && s_tready;
    assign room      = cnt_reg < CNT_W'(MAX_VERTICES);
    assign cnt_inc   = cnt_reg + CNT_W'(room);
    assign n_m1      = n_reg - CNT_W'(1);
    assign j_last    = ({1'b0, j_reg} == n_m1);
    assign k_addr    = j_last ? '0 : j_reg + 1'b1;
    assign degen_now = !stat.ok1 || !stat.ok2 || stat.den_zero;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        init_next  = init_reg;
        degen_next = degen_reg;
        cmd        = '0;
        cmd.mul_sel  = MUL_NONE;
        cmd.acc_op   = ACC_HOLD;
        cmd.div_dest = DIV_NX;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cmd.wr_en   = room;
                    cmd.wr_addr = cnt_reg[ADDR_W-1:0];
                    cnt_next    = cnt_inc;
                    if (s_tlast)
                    begin
                        n_next     = cnt_inc;
                        init_next  = 1'b1;
                        state_next = ST_INIT_A;
                    end
                end
            end
            ST_INIT_A:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = n_m1[ADDR_W-1:0];
                state_next  = ST_INIT_B;
            end
            ST_INIT_B:
            begin
                cmd.ld_a    = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = '0;
                state_next  = ST_INIT_C;
            end
            ST_INIT_C:
            begin
                cmd.ld_b   = 1'b1;
                state_next = ST_EDGE;
            end
            ST_VRD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = k_addr;
                state_next  = ST_VCAP;
            end
            ST_VCAP:
            begin
                cmd.ld_b   = 1'b1;
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                cmd.mk_edge = 1'b1;
                state_next  = ST_SQ1;
            end
            ST_SQ1:
            begin
                cmd.mul_sel = MUL_DX2_DX2;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_SQ2;
            end
            ST_SQ2:
            begin
                cmd.mul_sel = MUL_DY2_DY2;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_LENCHK;
            end
            ST_LENCHK:
            begin
                if (stat.acc_zero)
                begin
                    cmd.zero_n2 = 1'b1;
                    state_next  = ST_NORM_DONE;
                end
                else
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT_WAIT;
                end
            end
            ST_SQRT_WAIT:
            begin
                if (stat.sqrt_done)
                begin
                    state_next = ST_PX;
                end
            end
            ST_PX:
            begin
                cmd.mul_sel = MUL_DY2_OFF;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_DX_GO;
            end
            ST_DX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_dest  = DIV_NX;
                state_next    = ST_DX_WAIT;
            end
            ST_DX_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_PY;
                end
            end
            ST_PY:
            begin
                cmd.mul_sel = MUL_DX2_OFF;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_DY_GO;
            end
            ST_DY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_dest  = DIV_NY;
                state_next    = ST_DY_WAIT;
            end
            ST_DY_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_NORM_DONE;
                end
            end
            ST_NORM_DONE:
            begin
                if (init_reg)
                begin
                    cmd.advance = 1'b1;
                    j_next      = '0;
                    init_next   = 1'b0;
                    state_next  = ST_VRD;
                end
                else
                begin
                    state_next = ST_DEN1;
                end
            end
            ST_DEN1:
            begin
                cmd.mul_sel = MUL_DY1_DX2;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_DEN2;
            end
            ST_DEN2:
            begin
                cmd.mul_sel = MUL_DX1_DY2;
                cmd.acc_op  = ACC_SUB;
                state_next  = ST_DEN3;
            end
            ST_DEN3:
            begin
                cmd.ld_den = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                degen_next = degen_now;
                if (degen_now)
                begin
                    cmd.clr_q  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_NUM1;
                end
            end
            ST_NUM1:
            begin
                cmd.mul_sel = MUL_DNX_DY2;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_NUM2;
            end
            ST_NUM2:
            begin
                cmd.mul_sel = MUL_DNY_DX2;
                cmd.acc_op  = ACC_ADD;
                state_next  = ST_NUM3;
            end
            ST_NUM3:
            begin
                cmd.ld_num = 1'b1;
                state_next = ST_MX1;
            end
            ST_MX1:
            begin
                cmd.mul_sel = MUL_DX1_NH;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MX2;
            end
            ST_MX2:
            begin
                cmd.mul_sel = MUL_DX1_NL;
                cmd.acc_op  = ACC_SHADD;
                state_next  = ST_MX_GO;
            end
            ST_MX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_dest  = DIV_QX;
                state_next    = ST_MX_WAIT;
            end
            ST_MX_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MY1;
                end
            end
            ST_MY1:
            begin
                cmd.mul_sel = MUL_DY1_NH;
                cmd.acc_op  = ACC_LOAD;
                state_next  = ST_MY2;
            end
            ST_MY2:
            begin
                cmd.mul_sel = MUL_DY1_NL;
                cmd.acc_op  = ACC_SHADD;
                state_next  = ST_MY_GO;
            end
            ST_MY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_dest  = DIV_QY;
                state_next    = ST_MY_WAIT;
            end
            ST_MY_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_last  = j_last;
                    cmd.emit_degen = degen_reg;
                    if (j_last)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        j_next      = j_reg + 1'b1;
                        state_next  = ST_VRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            n_reg     <= '0;
            j_reg     <= '0;
            init_reg  <= 1'b0;
            degen_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            init_reg  <= init_next;
            degen_reg <= degen_next;
        end
    end

endmodule

// File: hdl/polygon_vertex_offset_unit.sv
// ----------------------------------------------------------------------------
// polygon_vertex_offset_unit
// Enlarges one closed polygon by a fixed distance, vertex by vertex.
// ----------------------------------------------------------------------------
// Vertices stream in one beat per cycle into a 64-entry store; a beat with
// tlast closes the polygon (vertices past 64 are dropped, the tlast beat
// still closes it). The unit then stops taking input and emits one enlarged
// vertex per stored vertex, in order, with tlast on the final one. Each
// output is the meeting point of the two adjacent edges, each shifted along
// its left normal by the offset; a zero-length edge or parallel edges set
// tuser and give the vertex plus the incoming edge's normal. Once per
// polygon the closing edge's normal comes first; each output vertex then
// takes at most one square root and four divisions, the divisions on the
// shared one-bit-per-cycle divider, and a vertex flagged in tuser skips
// the two intersection divisions. A waiting final result does not block
// the next polygon from loading.
module polygon_vertex_offset_unit
    import pvo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // vertex input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*COORD_W-1:0] s_tdata,   // vertex_x [23:0], vertex_y [47:24]
    input  logic                 s_tlast,   // last_vertex
    // enlarged vertex output beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*COORD_W-1:0] m_tdata,   // out_x [23:0], out_y [47:24]
    output logic                 m_tuser,   // degenerate
    output logic                 m_tlast,   // last_out
    // offset distance register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [OFF_W-1:0]     cfg_data   // offset_distance, unsigned q8.8
);

    pvo_cmd_t  cmd;
    pvo_stat_t stat;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencer: load phase, per-vertex schedule, result hand-off
    pvo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, arithmetic units and output register
    pvo_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: hdl/pvo_checker.sv
// ----------------------------------------------------------------------------
// pvo_checker
// Port-level checks of the polygon vertex offset unit.
// ----------------------------------------------------------------------------
module pvo_checker
    import pvo_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [2*COORD_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // closing vertex ends the load phase
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still taken after closing vertex");

    // input side only drops after a closing vertex
    a_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tlast))
        else $error("input ready dropped without closing vertex");

    // input side reopens together with the final result of the polygon
    a_rise_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid && m_tlast)
        else $error("input ready returned before final result");

endmodule

bind polygon_vertex_offset_unit pvo_checker u_pvo_checker (.*);

// File: verif/polygon_vertex_offset_unit_test.sv
// ----------------------------------------------------------------------------
// polygon_vertex_offset_unit_test
// Self-checking bench for the polygon vertex offset unit.
// ----------------------------------------------------------------------------
// Vertex beats are queued by a stimulus process and pushed by a bursty
// driver. A monitor mirrors the vertex store, predicts every enlarged
// vertex with exact wide integer arithmetic when a polygon closes, and
// compares each output beat field by field with the oldest prediction.
// The offset register is rewritten between phases, while the unit is idle.
// ----------------------------------------------------------------------------
module polygon_vertex_offset_unit_test;
    import pvo_pkg::*;

    localparam int  HALF_PERIOD   = 6;
    localparam int  IDLE_LIMIT    = 20000;  // cycles with no beat moving anywhere
    localparam int  LONG_HOLD     = 3000;   // output back-pressure stretch
    localparam int  DRAIN_CYCLES  = 600;    // quiet time after the last result
    localparam int  REPORT_MAX    = 10;
    localparam longint CAP_MAG    = 64'd1 << 40;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } vertex_beat_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               degen;
        logic               last;
    } offset_vertex_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [2*COORD_W-1:0] s_tdata;   // vertex_x [23:0], vertex_y [47:24]
    logic                 s_tlast;   // last_vertex
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*COORD_W-1:0] m_tdata;   // out_x [23:0], out_y [47:24]
    logic                 m_tuser;   // degenerate
    logic                 m_tlast;   // last_out
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [OFF_W-1:0]     cfg_data;  // offset_distance

    polygon_vertex_offset_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // pending vertex beats and predicted enlarged vertices
    vertex_beat_t   vertex_queue[$];
    offset_vertex_t enlarged_queue[$];

    // mirror of the unit's state
    logic [COORD_W-1:0] store_x [MAX_VERTICES];
    logic [COORD_W-1:0] store_y [MAX_VERTICES];
    int                 stored_count;
    logic [OFF_W-1:0]   offset_q88;

    int mismatch_count;
    int idle_cycles;
    int hold_requests;

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor arithmetic
    // ------------------------------------------------------------------------

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
        begin
            bit_w = bit_w >> 2;
        end
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end
            else
            begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // round n/d to nearest, ties away from zero
    function automatic longint round_div(input longint n, input longint unsigned d);
        longint unsigned q;
        q = ((n < 0 ? -n : n) + d / 2) / d;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    // round a*b/c exactly, magnitude capped at 2^40
    function automatic longint capped_ratio(input longint a, input longint b,
                                            input longint c);
        logic [127:0] ua;
        logic [127:0] ub;
        logic [127:0] uc;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        ua   = 128'(a < 0 ? -a : a);
        ub   = 128'(b < 0 ? -b : b);
        uc   = 128'(c < 0 ? -c : c);
        neg  = ((a < 0) != (b < 0)) != (c < 0);
        prod = ua * ub;
        quo  = prod / uc;
        rem  = prod % uc;
        if (quo > 128'(CAP_MAG))
        begin
            quo = 128'(CAP_MAG);
        end
        else
        begin
            if (rem >= uc - rem)
            begin
                quo = quo + 1;
            end
            if (quo > 128'(CAP_MAG))
            begin
                quo = 128'(CAP_MAG);
            end
        end
        return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    // left normal of an edge scaled to the offset; zero and 0 for a null edge
    function automatic logic left_normal(input longint dx, input longint dy,
                                         output longint nx, output longint ny);
        longint unsigned len_sq;
        longint unsigned len_q14;
        longint          scaled_off;
        len_sq     = longint'(dx * dx + dy * dy);
        scaled_off = longint'(offset_q88) * 64;
        nx = 0;
        ny = 0;
        if (len_sq == 0)
        begin
            return 1'b0;
        end
        len_q14 = floor_sqrt(len_sq << LEN_SHIFT);
        nx = round_div(-dy * scaled_off, len_q14);
        ny = round_div(dx * scaled_off, len_q14);
        return 1'b1;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
        if (v > 64'sd8388607)
        begin
            return 24'h7fffff;
        end
        if (v < -64'sd8388608)
        begin
            return 24'h800000;
        end
        return v[COORD_W-1:0];
    endfunction

    // predict the whole enlarged polygon from the mirrored store
    task automatic predict_polygon();
        int             prev;
        int             next;
        longint         xj;
        longint         yj;
        longint         dx1;
        longint         dy1;
        longint         dx2;
        longint         dy2;
        longint         n1x;
        longint         n1y;
        longint         n2x;
        longint         n2y;
        longint         den;
        longint         num;
        longint         ox;
        longint         oy;
        logic           ok1;
        logic           ok2;
        offset_vertex_t res;
        for (int j = 0; j < stored_count; j++)
        begin
            prev = (j + stored_count - 1) % stored_count;
            next = (j + 1) % stored_count;
            xj   = longint'(signed'(store_x[j]));
            yj   = longint'(signed'(store_y[j]));
            dx1  = xj - longint'(signed'(store_x[prev]));
            dy1  = yj - longint'(signed'(store_y[prev]));
            dx2  = longint'(signed'(store_x[next])) - xj;
            dy2  = longint'(signed'(store_y[next])) - yj;
            ok1  = left_normal(dx1, dy1, n1x, n1y);
            ok2  = left_normal(dx2, dy2, n2x, n2y);
            den  = dy1 * dx2 - dx1 * dy2;
            res.degen = !ok1 || !ok2 || den == 0;
            ox = xj + n1x;
            oy = yj + n1y;
            if (!res.degen)
            begin
                num = (n1x - n2x) * dy2 + (n2y - n1y) * dx2;
                ox  = ox + capped_ratio(dx1, num, den);
                oy  = oy + capped_ratio(dy1, num, den);
            end
            res.x    = clamp_coord(ox);
            res.y    = clamp_coord(oy);
            res.last = (j == stored_count - 1);
            enlarged_queue.insert(enlarged_queue.size(), res);
        end
        stored_count = 0;
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (vertex_queue.size() > 0)
            begin
                vertex_beat_t b;
                b = vertex_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {b.y, b.x};
                s_tlast  <= b.last;
                if (burst_left <= 1)
                begin
                    // new burst; some bursts follow with no gap at all
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern that steps through four modes, plus long holds
    // ------------------------------------------------------------------------
    int rx_cycle;
    int hold_left;
    int holds_served;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_cycle     <= 0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (holds_served != hold_requests)
            begin
                holds_served <= hold_requests;
                hold_left    <= LONG_HOLD;
                m_tready     <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                case ((rx_cycle >> 8) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= (rx_cycle % 4) != 3;
                    2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: mirror inputs and config, check output beats
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_q88 = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (stored_count < MAX_VERTICES)
                begin
                    store_x[stored_count] = s_tdata[COORD_W-1:0];
                    store_y[stored_count] = s_tdata[2*COORD_W-1:COORD_W];
                    stored_count++;
                end
                if (s_tlast)
                begin
                    predict_polygon();
                end
            end
            if (m_tvalid && m_tready)
            begin
                offset_vertex_t want;
                offset_vertex_t got;
                got = {m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W], m_tuser, m_tlast};
                if (enlarged_queue.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("unexpected output beat x=%h y=%h degen=%b last=%b",
                                 got.x, got.y, got.degen, got.last);
                    end
                end
                else
                begin
                    want = enlarged_queue.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                        begin
                            $display("output beat: expected x=%h y=%h degen=%b last=%b,",
                                     want.x, want.y, want.degen, want.last,
                                     " got x=%h y=%h degen=%b last=%b",
                                     got.x, got.y, got.degen, got.last);
                        end
                    end
                end
            end
        end
    end

    // watchdog: any handshake resets the idle count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic add_vertex(input int x, input int y, input logic last);
        vertex_beat_t b;
        b.x    = x[COORD_W-1:0];
        b.y    = y[COORD_W-1:0];
        b.last = last;
        vertex_queue.insert(vertex_queue.size(), b);
    endtask

    // random polygon; shape picks geometry style
    task automatic add_random_polygon(input int count);
        int shape;
        int cx;
        int cy;
        int radius;
        int px;
        int py;
        shape  = $urandom_range(0, 9);
        cx     = $signed($urandom_range(0, 32'h1fffff)) - 32'h100000;
        cy     = $signed($urandom_range(0, 32'h1fffff)) - 32'h100000;
        radius = 1 << $urandom_range(4, 17);
        px     = cx;
        py     = cy;
        for (int v = 0; v < count; v++)
        begin
            if (shape < 6)
            begin
                // local cloud around a center, the common case
                px = cx + $signed($urandom_range(0, 2 * radius)) - radius;
                py = cy + $signed($urandom_range(0, 2 * radius)) - radius;
            end
            else if (shape < 8)
            begin
                // full-range coordinates, drives saturation and every bit
                px = $signed(24'($urandom())) ;
                py = $signed(24'($urandom()));
                px = (px << 8) >>> 8;
                py = (py << 8) >>> 8;
            end
            else if ($urandom_range(0, 2) != 0 && v > 0)
            begin
                // repeated or collinear vertices
                if ($urandom_range(0, 1) == 0)
                begin
                    px = px + radius;
                end
            end
            else
            begin
                px = cx + $signed($urandom_range(0, 2 * radius)) - radius;
                py = cy + $signed($urandom_range(0, 2 * radius)) - radius;
            end
            add_vertex(px, py, v == count - 1);
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (vertex_queue.size() != 0 || s_tvalid || enlarged_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int items);
        int sent;
        int count;
        sent = 0;
        while (sent < items)
        begin
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            add_random_polygon(count);
            sent += count;
        end
    endtask

    initial
    begin
        logic [OFF_W-1:0] offsets [5];
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_requests  = 0;
        stored_count   = 0;
        offset_q88     = OFF_RESET;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        rst_n          = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset offset
        add_vertex(0, 0, 1'b0);                 // square, counter-clockwise
        add_vertex(2560, 0, 1'b0);
        add_vertex(2560, 2560, 1'b0);
        add_vertex(0, 2560, 1'b1);
        add_vertex(0, 0, 1'b0);                 // triangle, clockwise
        add_vertex(0, 5000, 1'b0);
        add_vertex(7000, 0, 1'b1);
        add_vertex(-77, 123, 1'b1);             // single vertex
        add_vertex(100, 100, 1'b0);             // two vertices
        add_vertex(900, -300, 1'b1);
        add_vertex(0, 0, 1'b0);                 // collinear with a repeated vertex
        add_vertex(1000, 1000, 1'b0);
        add_vertex(1000, 1000, 1'b1);
        add_vertex(8388607, 8388607, 1'b0);     // extreme corners, saturates
        add_vertex(-8388608, 8388607, 1'b0);
        add_vertex(-8388608, -8388608, 1'b0);
        add_vertex(8388607, -8388608, 1'b1);
        add_vertex(0, 0, 1'b0);                 // concave arrow head, sharp spikes
        add_vertex(4000, 0, 1'b0);
        add_vertex(1000, 10, 1'b0);
        add_vertex(4000, 4000, 1'b0);
        add_vertex(0, 3, 1'b1);
        wait_idle();

        // random phases across offset settings, extremes included
        offsets[0] = 16'd0;
        offsets[1] = 16'hffff;
        offsets[2] = 16'd1;
        offsets[3] = OFF_RESET;
        offsets[4] = 16'($urandom());
        for (int p = 0; p < 5; p++)
        begin
            write_offset(offsets[p]);
            if (p == 1)
            begin
                // full store, then overflow with dropped vertices
                add_random_polygon(MAX_VERTICES);
                add_random_polygon(MAX_VERTICES + 6);
            end
            if (p == 2)
            begin
                // long output hold while input beats keep arriving
                hold_requests <= hold_requests + 1;
            end
            random_phase(p < 2 ? 40 : 70);
            wait_idle();
        end

        if (mismatch_count == 0 && enlarged_queue.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/pvo_pkg.sv
hdl/pvo_sqrt.sv
hdl/pvo_div.sv
hdl/pvo_datapath.sv
hdl/pvo_ctrl.sv
hdl/polygon_vertex_offset_unit.sv
hdl/pvo_checker.sv
verif/polygon_vertex_offset_unit_test.sv
